// ===== design/mtwg_pkg.sv =====
// Shared constants for the missing-tooth wheel generator.
package mtwg_pkg;

    localparam int RPM_W    = 16;
    localparam int RATE_W   = 20;
    localparam int TEETH_W  = 8;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int NUM_W    = 25;
    localparam int DEN_W    = TEETH_W + RPM_W;
    localparam int STEP_W   = $clog2(NUM_W);

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_SPEED = 1'b1;

    localparam logic [1:0] REG_TICK_RATE = 2'd0;
    localparam logic [1:0] REG_TEETH     = 2'd1;
    localparam logic [1:0] REG_MISSING   = 2'd2;

    localparam logic [RATE_W-1:0]  TICK_RATE_RST = RATE_W'(1000);
    localparam logic [TEETH_W-1:0] TEETH_RST     = TEETH_W'(60);
    localparam logic [TEETH_W-1:0] MISSING_RST   = TEETH_W'(2);
    localparam int                 INTERVAL_RST  = 200;

endpackage

// ===== design/mtwg_in_if.sv =====
// Input channel carrying tick and speed items.
interface mtwg_in_if import mtwg_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             operation;
    logic [RPM_W-1:0] rpm;

    modport source (output valid, output operation, output rpm, input ready);
    modport sink (input valid, input operation, input rpm, output ready);
endinterface

// ===== design/mtwg_out_if.sv =====
// Output channel carrying one result per input item.
interface mtwg_out_if import mtwg_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               pin_level;
    logic               edge_taken;
    logic [TEETH_W-1:0] tooth_index;

    modport source (output valid, output pin_level, output edge_taken, output tooth_index,
                    input ready);
    modport sink (input valid, input pin_level, input edge_taken, input tooth_index,
                  output ready);
endinterface

// ===== design/missing_tooth_wheel_generator_unit.sv =====
// Top level of the missing-tooth crank trigger wheel generator.
// A tick item is handled in the cycle of its transfer and its result is registered for the
// next cycle; ticks follow back to back, one per clock, while the result register drains.
// A speed item forms numerator and divisor in the cycle of its transfer, runs 25 steps of the
// restoring divider, then saturates the interval and registers the result once the result register is free.
// Reset is synchronous and active low; it restores the register and wheel state at once.
module missing_tooth_wheel_generator_unit import mtwg_pkg::*; #(
    parameter int INTERVAL_BITS = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mtwg_in_if.sink           i_item,
    mtwg_out_if.source        o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int QW = (INTERVAL_BITS > NUM_W) ? INTERVAL_BITS : NUM_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [RATE_W-1:0]        r_tick_rate;
    logic [TEETH_W-1:0]       r_teeth;
    logic [TEETH_W-1:0]       r_missing;

    logic [1:0]               r_state, n_state;
    logic [INTERVAL_BITS-1:0] r_interval, n_interval;
    logic [INTERVAL_BITS-1:0] r_tick_count, n_tick_count;
    logic [TEETH_W-1:0]       r_tooth, n_tooth;
    logic                     r_half, n_half;
    logic                     r_level, n_level;

    logic [NUM_W-1:0]         r_quo, n_quo;
    logic [DEN_W:0]           r_rem, n_rem;
    logic [DEN_W-1:0]         r_den, n_den;
    logic                     r_den_zero, n_den_zero;
    logic [STEP_W-1:0]        r_step, n_step;

    logic                     r_out_valid, n_out_valid;
    logic                     r_out_pin, n_out_pin;
    logic                     r_out_edge, n_out_edge;
    logic [TEETH_W-1:0]       r_out_tooth, n_out_tooth;

    logic                     in_fire;
    logic                     out_fire;
    logic                     slot_free;
    logic                     cfg_write;
    logic                     is_edge;
    logic [RPM_W-1:0]         rpm_eff;
    logic [TEETH_W-1:0]       tooth_inc;
    logic [INTERVAL_BITS-1:0] count_inc;
    logic [DEN_W:0]           rem_sh;
    logic [DEN_W+1:0]         rem_diff;
    logic                     rem_ge;
    logic [QW-1:0]            q_ext;
    logic [QW-1:0]            q_max;
    logic [QW-1:0]            q_sat;

    assign slot_free = !r_out_valid || o_result.ready;
    assign i_item.ready = (r_state == ST_IDLE) && slot_free;
    assign in_fire = i_item.valid && i_item.ready;
    assign out_fire = r_out_valid && o_result.ready;

    assign o_result.valid       = r_out_valid;
    assign o_result.pin_level   = r_out_pin;
    assign o_result.edge_taken  = r_out_edge;
    assign o_result.tooth_index = r_out_tooth;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_TICK_RATE: prdata = DATA_W'(r_tick_rate);
            REG_TEETH:     prdata = DATA_W'(r_teeth);
            REG_MISSING:   prdata = DATA_W'(r_missing);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_rate <= TICK_RATE_RST;
            r_teeth     <= TEETH_RST;
            r_missing   <= MISSING_RST;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_TICK_RATE: r_tick_rate <= pwdata[RATE_W-1:0];
                REG_TEETH:     r_teeth     <= pwdata[TEETH_W-1:0];
                REG_MISSING:   r_missing   <= pwdata[TEETH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign is_edge   = (r_tick_count == '0);
    assign tooth_inc = r_tooth + 1'b1;
    assign count_inc = r_tick_count + 1'b1;
    assign rpm_eff   = (i_item.rpm == '0) ? RPM_W'(1) : i_item.rpm;

    assign rem_sh   = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
    assign rem_diff = {1'b0, rem_sh} - {2'b00, r_den};
    assign rem_ge   = !rem_diff[DEN_W+1];

    assign q_ext = QW'(r_quo);
    assign q_max = QW'({INTERVAL_BITS{1'b1}});

    always_comb begin
        if (r_den_zero || (q_ext > q_max)) begin
            q_sat = q_max;
        end else if (q_ext == '0) begin
            q_sat = QW'(1);
        end else begin
            q_sat = q_ext;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_interval   = r_interval;
        n_tick_count = r_tick_count;
        n_tooth      = r_tooth;
        n_half       = r_half;
        n_level      = r_level;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_den        = r_den;
        n_den_zero   = r_den_zero;
        n_step       = r_step;
        n_out_valid  = out_fire ? 1'b0 : r_out_valid;
        n_out_pin    = r_out_pin;
        n_out_edge   = r_out_edge;
        n_out_tooth  = r_out_tooth;

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_item.operation == OP_SPEED) begin
                        n_quo      = {r_tick_rate, 5'b00000} - {4'b0000, r_tick_rate, 1'b0};
                        n_den      = DEN_W'(r_teeth) * DEN_W'(rpm_eff);
                        n_den_zero = (r_teeth == '0);
                        n_rem      = '0;
                        n_step     = '0;
                        n_state    = ST_DIV;
                    end else begin
                        if (is_edge) begin
                            if (({1'b0, r_tooth} + {1'b0, r_missing}) < {1'b0, r_teeth}) begin
                                n_level = !r_level;
                            end
                            if (r_half) begin
                                n_tooth = (tooth_inc >= r_teeth) ? '0 : tooth_inc;
                            end
                            n_half = !r_half;
                        end
                        n_tick_count = (count_inc >= r_interval) ? '0 : count_inc;
                        n_out_valid  = 1'b1;
                        n_out_pin    = n_level;
                        n_out_edge   = is_edge;
                        n_out_tooth  = n_tooth;
                    end
                end
            end
            ST_DIV: begin
                n_rem = rem_ge ? rem_diff[DEN_W:0] : rem_sh;
                n_quo = {r_quo[NUM_W-2:0], rem_ge};
                if (r_step == STEP_W'(NUM_W - 1)) begin
                    n_state = ST_DONE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    n_interval  = q_sat[INTERVAL_BITS-1:0];
                    n_out_valid = 1'b1;
                    n_out_pin   = r_level;
                    n_out_edge  = 1'b0;
                    n_out_tooth = r_tooth;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_interval   <= INTERVAL_BITS'(INTERVAL_RST);
            r_tick_count <= '0;
            r_tooth      <= '0;
            r_half       <= 1'b0;
            r_level      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_interval   <= n_interval;
            r_tick_count <= n_tick_count;
            r_tooth      <= n_tooth;
            r_half       <= n_half;
            r_level      <= n_level;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo       <= n_quo;
        r_rem       <= n_rem;
        r_den       <= n_den;
        r_den_zero  <= n_den_zero;
        r_step      <= n_step;
        r_out_pin   <= n_out_pin;
        r_out_edge  <= n_out_edge;
        r_out_tooth <= n_out_tooth;
    end

    a_ready_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.ready |-> slot_free)
        else $error("Input taken while the result register cannot be freed.");

    a_speed_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_item.operation == OP_SPEED)) |=> (!i_item.ready && (r_state == ST_DIV)))
        else $error("Speed transfer did not start the divider.");

    a_div_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |=> ((r_state == ST_DIV) || (r_state == ST_DONE)))
        else $error("Divider left its sequence early.");

    a_speed_no_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && slot_free) |=> (r_out_valid && !r_out_edge))
        else $error("Speed result flagged as an edge.");

endmodule
